[rtl/core/ttm_pkg.sv]
// Package for the tilt/tap menu controller: menu codes, limits,
// configuration and state types, and the tilt debounce function.
// No dependencies.
package ttm_pkg;

  // Menu state codes
  localparam logic [4:0] ST_FADE      = 5'd0;
  localparam logic [4:0] ST_TIME      = 5'd1;
  localparam logic [4:0] ST_TIME_S    = 5'd2;
  localparam logic [4:0] ST_FLIP      = 5'd3;
  localparam logic [4:0] ST_DATE      = 5'd4;
  localparam logic [4:0] ST_FLIP_DATE = 5'd5;
  localparam logic [4:0] ST_SET_HOUR  = 5'd6;
  localparam logic [4:0] ST_SET_MIN   = 5'd7;
  localparam logic [4:0] ST_SET_DAY   = 5'd8;
  localparam logic [4:0] ST_SET_MONTH = 5'd9;
  localparam logic [4:0] ST_SET_YEAR  = 5'd10;
  localparam logic [4:0] ST_STEPS     = 5'd11;
  localparam logic [4:0] ST_HISTORY   = 5'd12;
  localparam logic [4:0] ST_BATT      = 5'd13;

  // Flip gesture phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_FLIPPED = 2'd1;
  localparam logic [1:0] PH_SETTING = 2'd3;

  // Screen-on requests in seconds
  localparam logic [5:0] ON_NONE      = 6'd0;
  localparam logic [5:0] ON_SHORT     = 6'd4;
  localparam logic [5:0] ON_LONG      = 6'd30;
  localparam logic [5:0] ON_VERY_LONG = 6'd60;

  // Clock field selects
  localparam logic [2:0] ADJ_NONE  = 3'd0;
  localparam logic [2:0] ADJ_HOUR  = 3'd1;
  localparam logic [2:0] ADJ_MIN   = 3'd2;
  localparam logic [2:0] ADJ_DAY   = 3'd3;
  localparam logic [2:0] ADJ_MONTH = 3'd4;
  localparam logic [2:0] ADJ_YEAR  = 3'd5;

  // Acceleration thresholds
  localparam logic signed [15:0] TILT_LIMIT = 16'sd1024;
  localparam logic signed [15:0] FLIP_LIMIT = 16'sd7000;
  localparam logic signed [15:0] SIDE_LIMIT = 16'sd300;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_EN_DATE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EN_SECONDS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EN_HISTORY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_DEBOUNCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HIST_DEBOUNCE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HIST_ENTRIES = 3'd5;

  // Tilt counters never leave +/-1024, so 12 signed bits suffice
  localparam int unsigned CNT_W = 12;

  typedef struct packed {
    logic       enable_date;
    logic       enable_seconds;
    logic       enable_step_history;
    logic [9:0] set_debounce;
    logic [9:0] history_debounce;
    logic [8:0] history_entries;
  } cfg_t;

  typedef struct packed {
    logic [4:0]              menu;
    logic [1:0]              phase;
    logic signed [CNT_W-1:0] set_cnt;
    logic signed [CNT_W-1:0] hist_cnt;
    logic [7:0]              hist_ptr;
  } state_t;

  typedef struct packed {
    logic [4:0] shown_state;
    logic [4:0] menu_state;
    logic [5:0] prolong_seconds;
    logic [2:0] adjust_unit;
    logic       adjust_down;
    logic       save_time;
    logic       clear_seconds;
    logic       update_time;
    logic [7:0] history_index;
  } res_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] cnt;
    logic                    up;
    logic                    dn;
  } tilt_t;

  // One debounce step: count while tilted, fire and clear past the threshold
  function automatic tilt_t tilt_step(logic signed [CNT_W-1:0] cnt,
                                      logic signed [15:0] y,
                                      logic [9:0] thr);
    tilt_t                   t;
    logic signed [CNT_W-1:0] c;
    logic signed [CNT_W-1:0] thr_s;
    thr_s = $signed({{(CNT_W-10){1'b0}}, thr});
    if (y > TILT_LIMIT) begin
      c = cnt + 12'sd1;
    end else if (y < -TILT_LIMIT) begin
      c = cnt - 12'sd1;
    end else begin
      c = '0;
    end
    t.up = 1'b0;
    t.dn = 1'b0;
    t.cnt = c;
    if (c > thr_s) begin
      t.up = 1'b1;
      t.cnt = '0;
    end else if (c < -thr_s) begin
      t.dn = 1'b1;
      t.cnt = '0;
    end
    return t;
  endfunction

endpackage

[rtl/core/ttm_if.sv]
// Request channel interfaces: accelerometer samples in, menu results out.
// Depends on nothing.
interface ttm_in_if;
  logic               valid;
  logic               ready;
  logic               tap;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;

  modport source (output valid, output tap, output accel_y, output accel_z, input ready);
  modport sink   (input valid, input tap, input accel_y, input accel_z, output ready);
endinterface

interface ttm_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] shown_state;
  logic [4:0] menu_state;
  logic [5:0] prolong_seconds;
  logic [2:0] adjust_unit;
  logic       adjust_down;
  logic       save_time;
  logic       clear_seconds;
  logic       update_time;
  logic [7:0] history_index;

  modport source (output valid, output shown_state, output menu_state,
                  output prolong_seconds, output adjust_unit, output adjust_down,
                  output save_time, output clear_seconds, output update_time,
                  output history_index, input ready);
  modport sink   (input valid, input shown_state, input menu_state,
                  input prolong_seconds, input adjust_unit, input adjust_down,
                  input save_time, input clear_seconds, input update_time,
                  input history_index, output ready);
endinterface

[rtl/core/ttm_cfg_regs.sv]
// Configuration register file of the menu controller.
// Depends on ttm_pkg.
module ttm_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ttm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ttm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output ttm_pkg::cfg_t                  cfg_o
);
  import ttm_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_date         <= 1'b1;
      cfg_q.enable_seconds      <= 1'b0;
      cfg_q.enable_step_history <= 1'b0;
      cfg_q.set_debounce        <= 10'd50;
      cfg_q.history_debounce    <= 10'd50;
      cfg_q.history_entries     <= 9'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EN_DATE:       cfg_q.enable_date         <= cfg_wdata_i[0];
        CFG_EN_SECONDS:    cfg_q.enable_seconds      <= cfg_wdata_i[0];
        CFG_EN_HISTORY:    cfg_q.enable_step_history <= cfg_wdata_i[0];
        CFG_SET_DEBOUNCE:  cfg_q.set_debounce        <= cfg_wdata_i[9:0];
        CFG_HIST_DEBOUNCE: cfg_q.history_debounce    <= cfg_wdata_i[9:0];
        CFG_HIST_ENTRIES:  cfg_q.history_entries     <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/ttm_step.sv]
// Per-sample decision logic: next menu state, gesture phase, tilt
// counters, history index and result fields. Depends on ttm_pkg.
module ttm_step (
  input  ttm_pkg::cfg_t      cfg_i,
  input  ttm_pkg::state_t    st_i,
  input  logic               tap_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  output ttm_pkg::state_t    st_o,
  output ttm_pkg::res_t      res_o
);
  import ttm_pkg::*;

  logic       fade;
  logic [4:0] cur;
  logic [5:0] req;
  logic [2:0] set_unit;
  logic [7:0] hist_top;
  tilt_t      set_t;
  tilt_t      hist_t;

  assign set_t    = tilt_step(st_i.set_cnt, accel_y_i, cfg_i.set_debounce);
  assign hist_t   = tilt_step(st_i.hist_cnt, accel_y_i, cfg_i.history_debounce);
  assign hist_top = 8'(cfg_i.history_entries - 9'd1);

  always_comb begin
    st_o     = st_i;
    res_o    = '0;
    req      = ON_NONE;
    set_unit = ADJ_NONE;
    fade     = (st_i.menu == ST_FADE);
    // fade-in falls through to the time view on the same sample
    cur      = fade ? ST_TIME : st_i.menu;
    st_o.menu = cur;

    unique case (cur)
      ST_FLIP, ST_TIME_S, ST_TIME: begin
        if (tap_i) begin
          if (st_i.phase == PH_IDLE) begin
            if (accel_z_i > FLIP_LIMIT) begin
              st_o.phase = PH_FLIPPED;
              st_o.menu  = ST_FLIP;
              req        = ON_SHORT;
            end else if (accel_y_i > SIDE_LIMIT && cfg_i.enable_date) begin
              st_o.menu = ST_DATE;
              req       = ON_SHORT;
            end else if (accel_y_i < -SIDE_LIMIT) begin
              st_o.menu = ST_STEPS;
              req       = ON_SHORT;
            end else if (cfg_i.enable_seconds) begin
              if (cur == ST_TIME_S) begin
                st_o.menu = ST_TIME;
                req       = ON_SHORT;
              end else begin
                st_o.menu = ST_TIME_S;
                req       = ON_LONG;
              end
            end else begin
              st_o.menu = ST_STEPS;
              req       = ON_SHORT;
            end
          end else if (st_i.phase == PH_FLIPPED) begin
            if (accel_z_i < -FLIP_LIMIT) begin
              st_o.menu  = ST_SET_HOUR;
              st_o.phase = PH_SETTING;
              req        = ON_VERY_LONG;
            end else begin
              st_o.menu  = ST_TIME;
              st_o.phase = PH_IDLE;
              req        = ON_SHORT;
            end
          end else if (st_i.phase == PH_SETTING) begin
            st_o.phase = PH_IDLE;
          end
        end
      end
      ST_FLIP_DATE, ST_DATE: begin
        if (tap_i) begin
          if (st_i.phase == PH_IDLE) begin
            if (accel_z_i > FLIP_LIMIT) begin
              st_o.phase = PH_FLIPPED;
              st_o.menu  = ST_FLIP_DATE;
              req        = ON_SHORT;
            end else begin
              st_o.menu = ST_TIME;
              req       = ON_SHORT;
            end
          end else if (st_i.phase == PH_FLIPPED) begin
            if (accel_z_i < -FLIP_LIMIT) begin
              st_o.menu  = ST_SET_DAY;
              st_o.phase = PH_SETTING;
              req        = ON_VERY_LONG;
            end else begin
              st_o.menu  = ST_DATE;
              st_o.phase = PH_IDLE;
              req        = ON_SHORT;
            end
          end else if (st_i.phase == PH_SETTING) begin
            st_o.phase = PH_IDLE;
          end
        end
      end
      ST_SET_HOUR: begin
        set_unit = ADJ_HOUR;
        if (tap_i) begin
          st_o.menu = ST_SET_MIN;
          req       = ON_VERY_LONG;
        end
      end
      ST_SET_MIN: begin
        set_unit = ADJ_MIN;
        if (tap_i) begin
          st_o.menu           = ST_TIME;
          res_o.clear_seconds = 1'b1;
          res_o.save_time     = 1'b1;
          req                 = ON_SHORT;
        end
      end
      ST_SET_DAY: begin
        set_unit = ADJ_DAY;
        if (tap_i) begin
          st_o.menu = ST_SET_MONTH;
          req       = ON_VERY_LONG;
        end
      end
      ST_SET_MONTH: begin
        set_unit = ADJ_MONTH;
        if (tap_i) begin
          st_o.menu = ST_SET_YEAR;
          req       = ON_VERY_LONG;
        end
      end
      ST_SET_YEAR: begin
        set_unit = ADJ_YEAR;
        if (tap_i) begin
          st_o.menu       = ST_DATE;
          res_o.save_time = 1'b1;
          req             = ON_SHORT;
        end
      end
      ST_STEPS: begin
        if (tap_i) begin
          if (accel_z_i > FLIP_LIMIT && cfg_i.enable_step_history) begin
            st_o.menu = ST_HISTORY;
            req       = ON_VERY_LONG;
          end else begin
            st_o.menu = ST_TIME;
            req       = ON_SHORT;
          end
        end
      end
      ST_HISTORY: begin
        if (tap_i) begin
          st_o.hist_cnt = '0;
          st_o.menu     = ST_BATT;
          req           = ON_SHORT;
        end else begin
          st_o.hist_cnt = hist_t.cnt;
          if (hist_t.up) begin
            st_o.hist_ptr = (st_i.hist_ptr == hist_top) ? 8'd0 : st_i.hist_ptr + 8'd1;
          end else if (hist_t.dn) begin
            st_o.hist_ptr = (st_i.hist_ptr == 8'd0) ? hist_top : st_i.hist_ptr - 8'd1;
          end
        end
      end
      ST_BATT: begin
        if (tap_i) begin
          st_o.menu = ST_TIME;
          req       = ON_SHORT;
        end
      end
      default: begin
        // error, raw output, empty and unused codes
        st_o.menu = ST_TIME;
      end
    endcase

    // field stepping; phase is left alone in the set views
    if (set_unit != ADJ_NONE && st_i.phase == PH_SETTING) begin
      st_o.set_cnt = set_t.cnt;
      if (set_t.up || set_t.dn) begin
        res_o.adjust_unit = set_unit;
        res_o.adjust_down = set_t.dn;
      end
    end

    res_o.shown_state     = st_i.menu;
    res_o.menu_state      = st_o.menu;
    res_o.prolong_seconds = (fade && req == ON_NONE) ? ON_SHORT : req;
    res_o.update_time     = !(st_i.menu >= ST_SET_HOUR && st_i.menu <= ST_SET_YEAR);
    res_o.history_index   = st_o.hist_ptr;
  end

endmodule

[rtl/core/tilt_tap_menu_controller.sv]
// Tilt/tap menu controller top level: sample register, decision logic,
// result register. Depends on ttm_pkg, ttm_if, ttm_cfg_regs, ttm_step.
// Flow: an accepted request is held in the sample register and moves on to
// the result register when that one is free or draining; its result is registered.
// Throughput: one sample per cycle while out_o.ready does not stall the result register.
// Reset: asynchronous, active low; menu returns to fade-in, counters clear.
module tilt_tap_menu_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ttm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ttm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  ttm_in_if.sink                         in_i,
  ttm_out_if.source                      out_o
);
  import ttm_pkg::*;

  cfg_t               cfg;
  state_t             st_q;
  state_t             st_d;
  res_t               res_d;
  res_t               res_q;
  logic               in_vld_q;
  logic               in_tap_q;
  logic signed [15:0] in_y_q;
  logic signed [15:0] in_z_q;
  logic               out_vld_q;
  logic               advance;

  ttm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ttm_step u_step (
    .cfg_i     (cfg),
    .st_i      (st_q),
    .tap_i     (in_tap_q),
    .accel_y_i (in_y_q),
    .accel_z_i (in_z_q),
    .st_o      (st_d),
    .res_o     (res_d)
  );

  // sample moves to the result register when that one is free or draining
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '{menu: ST_FADE, phase: PH_IDLE, set_cnt: '0, hist_cnt: '0,
                     hist_ptr: '0};
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        st_q      <= st_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_tap_q <= in_i.tap;
      in_y_q   <= in_i.accel_y;
      in_z_q   <= in_i.accel_z;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.shown_state     = res_q.shown_state;
  assign out_o.menu_state      = res_q.menu_state;
  assign out_o.prolong_seconds = res_q.prolong_seconds;
  assign out_o.adjust_unit     = res_q.adjust_unit;
  assign out_o.adjust_down     = res_q.adjust_down;
  assign out_o.save_time       = res_q.save_time;
  assign out_o.clear_seconds   = res_q.clear_seconds;
  assign out_o.update_time     = res_q.update_time;
  assign out_o.history_index   = res_q.history_index;

endmodule

[rtl/core/ttm_checker.sv]
// Port-level checks for the tilt/tap menu controller, bound to the top.
// Depends on ttm_pkg and tilt_tap_menu_controller.
module ttm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [4:0] shown_state_i,
  input logic [4:0] menu_state_i,
  input logic [2:0] adjust_unit_i,
  input logic       adjust_down_i,
  input logic       save_time_i,
  input logic       clear_seconds_i,
  input logic       update_time_i
);
  import ttm_pkg::*;

  // a stalled result keeps its menu fields
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(shown_state_i) && $stable(menu_state_i))
    else $error("result changed while stalled");

  a_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> update_time_i == !(shown_state_i >= ST_SET_HOUR &&
                                       shown_state_i <= ST_SET_YEAR))
    else $error("update_time disagrees with shown state");

  a_adjust_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && adjust_unit_i != ADJ_NONE |->
      shown_state_i >= ST_SET_HOUR && shown_state_i <= ST_SET_YEAR &&
      {2'b00, adjust_unit_i} == shown_state_i - 5'd5)
    else $error("field adjust outside matching set view");

  a_down_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && adjust_unit_i == ADJ_NONE |-> !adjust_down_i)
    else $error("adjust_down without a field");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && clear_seconds_i |->
      save_time_i && shown_state_i == ST_SET_MIN && menu_state_i == ST_TIME)
    else $error("clear_seconds outside minute exit");

endmodule

bind tilt_tap_menu_controller ttm_checker u_ttm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .shown_state_i   (out_o.shown_state),
  .menu_state_i    (out_o.menu_state),
  .adjust_unit_i   (out_o.adjust_unit),
  .adjust_down_i   (out_o.adjust_down),
  .save_time_i     (out_o.save_time),
  .clear_seconds_i (out_o.clear_seconds),
  .update_time_i   (out_o.update_time)
);
